// ----- rtl/core/shfs_pkg.sv -----
// Shared types and constants for the servo health and fault supervisor.
// Used by shfs_ctrl, shfs_datapath and servo_health_fault_supervisor; no dependencies.
package shfs_pkg;

    localparam int MOTORS_DEFAULT = 6;

    localparam int OP_W    = 3;
    localparam int ID_W    = 8;
    localparam int MV_W    = 16;
    localparam int TEMP_W  = 8;
    localparam int CODE_W  = 3;
    localparam int MASK_W  = 6;
    localparam int SLOT_W  = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Event selects
    localparam logic [OP_W-1:0] OP_CLEAR_ALL   = 3'd0;
    localparam logic [OP_W-1:0] OP_PROBE       = 3'd1;
    localparam logic [OP_W-1:0] OP_ADVANCE     = 3'd2;
    localparam logic [OP_W-1:0] OP_HEALTH      = 3'd3;
    localparam logic [OP_W-1:0] OP_FAULT_CLEAR = 3'd4;

    // Fault codes
    localparam logic [CODE_W-1:0] FC_NONE      = 3'd0;
    localparam logic [CODE_W-1:0] FC_VOLT_LOW  = 3'd1;
    localparam logic [CODE_W-1:0] FC_VOLT_HIGH = 3'd2;
    localparam logic [CODE_W-1:0] FC_TEMP_CRIT = 3'd3;
    localparam logic [CODE_W-1:0] FC_TEMP_WARN = 3'd4;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_VOLT_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VOLT_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TEMP_CRIT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TEMP_WARN = 2'd3;

    // Configuration reset values
    localparam logic [MV_W-1:0]   VOLT_LOW_RST  = 16'd6000;
    localparam logic [MV_W-1:0]   VOLT_HIGH_RST = 16'd8400;
    localparam logic [TEMP_W-1:0] TEMP_CRIT_RST = 8'd70;
    localparam logic [TEMP_W-1:0] TEMP_WARN_RST = 8'd60;

    // Controller to datapath commands
    typedef struct packed {
        logic load;   // capture the accepted item
        logic exec;   // apply the event
        logic step;   // one slot of a walk
        logic emit;   // move the result into the output register
    } shfs_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic scan_req;   // the event needs a slot walk
        logic scan_done;  // the walk finishes in this step
        logic out_free;   // output register can take a result
    } shfs_stat_t;

endpackage

// ----- rtl/core/shfs_ctrl.sv -----
// Sequencer for the servo health and fault supervisor.
// Depends on shfs_pkg (command and status structs).
module shfs_ctrl
    import shfs_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  shfs_stat_t stat,
    output shfs_cmd_t  cmd
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_EXEC = 4'b0010,
        ST_SCAN = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                cmd.exec   = 1'b1;
                state_next = stat.scan_req ? ST_SCAN : ST_DONE;
            end
            ST_SCAN: begin
                cmd.step = 1'b1;
                if (stat.scan_done) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (stat.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- rtl/core/shfs_datapath.sv -----
// Slot state, counters, fault checks and output register of the supervisor.
// Depends on shfs_pkg; driven by shfs_ctrl through shfs_cmd_t.
module shfs_datapath
    import shfs_pkg::*;
#(
    parameter int MOTORS = MOTORS_DEFAULT
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  shfs_cmd_t             cmd,
    output shfs_stat_t            stat,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic [OP_W-1:0]       s_op,
    input  logic [ID_W-1:0]       s_servo_id,
    input  logic                  s_responded,
    input  logic [MV_W-1:0]       s_voltage_mv,
    input  logic                  s_voltage_valid,
    input  logic [TEMP_W-1:0]     s_temp_c,
    input  logic                  s_temp_valid,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [SLOT_W-1:0]     m_slot_index,
    output logic                  m_slot_found,
    output logic                  m_fault_event,
    output logic [SLOT_W-1:0]     m_fault_servo_id,
    output logic [CODE_W-1:0]     m_fault_kind,
    output logic [MV_W-1:0]       m_fault_reading,
    output logic [MASK_W-1:0]     m_torque_off_mask,
    output logic [MASK_W-1:0]     m_torque_on_mask,
    output logic [MASK_W-1:0]     m_active_mask,
    output logic [SLOT_W-1:0]     m_active_count
);

    localparam int IW = (MOTORS > 1) ? $clog2(MOTORS) : 1;
    localparam int CW = $clog2(MOTORS + 1);
    localparam logic [IW-1:0] LAST_SLOT = IW'(MOTORS - 1);
    localparam logic [CW-1:0] LAST_TRY  = CW'(MOTORS - 1);
    localparam logic [ID_W-1:0] ID_MAX  = ID_W'(MOTORS);

    // Captured item
    logic [OP_W-1:0]   op_reg;
    logic [ID_W-1:0]   id_reg;
    logic              resp_reg;
    logic [MV_W-1:0]   mv_reg;
    logic              mv_ok_reg;
    logic [TEMP_W-1:0] temp_reg;
    logic              temp_ok_reg;

    // Configuration
    logic [MV_W-1:0]   volt_low_reg,  volt_low_next;
    logic [MV_W-1:0]   volt_high_reg, volt_high_next;
    logic [TEMP_W-1:0] temp_crit_reg, temp_crit_next;
    logic [TEMP_W-1:0] temp_warn_reg, temp_warn_next;

    // Slot state: a slot is absent when neither bit is set
    logic [MOTORS-1:0] active_reg, active_next;
    logic [MOTORS-1:0] fault_reg,  fault_next;
    logic [CW-1:0]     count_reg,  count_next;
    logic [IW-1:0]     health_reg, health_next;
    logic [IW-1:0]     ptr_reg,    ptr_next;
    logic [CW-1:0]     tries_reg,  tries_next;

    // Result under construction
    logic              found_reg, found_next;
    logic              event_reg, event_next;
    logic [SLOT_W-1:0] evid_reg,  evid_next;
    logic [CODE_W-1:0] code_reg,  code_next;
    logic [MV_W-1:0]   val_reg,   val_next;
    logic [MOTORS-1:0] off_reg,   off_next;
    logic [MOTORS-1:0] on_reg,    on_next;

    logic m_valid_reg, m_valid_next;

    logic              id_in_range;
    logic [ID_W-1:0]   id_m1;
    logic [IW-1:0]     sidx;
    logic [IW-1:0]     ptr_inc;
    logic [IW:0]       health_p1;
    logic              fault_hit;
    logic [CODE_W-1:0] fc;
    logic [MV_W-1:0]   fv;

    assign id_in_range = (id_reg != '0) && (id_reg <= ID_MAX);
    assign id_m1       = id_reg - 1'b1;
    assign sidx        = id_m1[IW-1:0];
    assign ptr_inc     = (ptr_reg == LAST_SLOT) ? '0 : ptr_reg + 1'b1;
    assign health_p1   = {1'b0, health_reg} + 1'b1;

    // Threshold checks on captured readings; critical temp overrides voltage
    always_comb begin
        fault_hit = 1'b0;
        fc        = FC_NONE;
        fv        = '0;
        if (mv_ok_reg) begin
            if (mv_reg < volt_low_reg) begin
                fault_hit = 1'b1;
                fc        = FC_VOLT_LOW;
                fv        = mv_reg;
            end else if (mv_reg > volt_high_reg) begin
                fault_hit = 1'b1;
                fc        = FC_VOLT_HIGH;
                fv        = mv_reg;
            end
        end
        if (temp_ok_reg) begin
            if (temp_reg > temp_crit_reg) begin
                fault_hit = 1'b1;
                fc        = FC_TEMP_CRIT;
                fv        = MV_W'(temp_reg);
            end else if ((temp_reg > temp_warn_reg) && !fault_hit) begin
                fault_hit = 1'b1;
                fc        = FC_TEMP_WARN;
                fv        = MV_W'(temp_reg);
            end
        end
    end

    always_comb begin
        active_next = active_reg;
        fault_next  = fault_reg;
        count_next  = count_reg;
        health_next = health_reg;
        ptr_next    = ptr_reg;
        tries_next  = tries_reg;
        found_next  = found_reg;
        event_next  = event_reg;
        evid_next   = evid_reg;
        code_next   = code_reg;
        val_next    = val_reg;
        off_next    = off_reg;
        on_next     = on_reg;

        stat.scan_req  = (op_reg == OP_ADVANCE) ||
                         ((op_reg == OP_FAULT_CLEAR) && (id_reg == '0));
        stat.scan_done = 1'b0;
        stat.out_free  = !m_valid_reg || m_ready;

        if (cmd.exec) begin
            found_next = 1'b0;
            event_next = 1'b0;
            evid_next  = '0;
            code_next  = FC_NONE;
            val_next   = '0;
            off_next   = '0;
            on_next    = '0;
            ptr_next   = '0;
            tries_next = '0;
            case (op_reg)
                OP_CLEAR_ALL: begin
                    off_next    = active_reg | fault_reg;
                    active_next = '0;
                    fault_next  = '0;
                    count_next  = '0;
                end
                OP_PROBE: begin
                    if (id_in_range && resp_reg && !active_reg[sidx] && !fault_reg[sidx]) begin
                        active_next[sidx] = 1'b1;
                        count_next        = count_reg + 1'b1;
                        on_next[sidx]     = 1'b1;
                    end
                end
                OP_ADVANCE: begin
                    ptr_next = health_reg;
                end
                OP_HEALTH: begin
                    if (fault_hit && active_reg[health_reg]) begin
                        active_next[health_reg] = 1'b0;
                        fault_next[health_reg]  = 1'b1;
                        if (count_reg != '0) begin
                            count_next = count_reg - 1'b1;
                        end
                        off_next[health_reg] = 1'b1;
                        event_next = 1'b1;
                        evid_next  = SLOT_W'(health_p1);
                        code_next  = fc;
                        val_next   = fv;
                    end
                end
                OP_FAULT_CLEAR: begin
                    if (id_in_range && fault_reg[sidx]) begin
                        fault_next[sidx]  = 1'b0;
                        active_next[sidx] = 1'b1;
                        count_next        = count_reg + 1'b1;
                        on_next[sidx]     = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end

        if (cmd.step) begin
            if (op_reg == OP_ADVANCE) begin
                // Step once, then keep going past absent slots
                ptr_next   = ptr_inc;
                tries_next = tries_reg + 1'b1;
                if (active_reg[ptr_inc] || fault_reg[ptr_inc] || (tries_reg == LAST_TRY)) begin
                    stat.scan_done = 1'b1;
                    health_next    = ptr_inc;
                    found_next     = active_reg[ptr_inc] || fault_reg[ptr_inc];
                end
            end else begin
                // Release every faulted slot, one per cycle
                if (fault_reg[ptr_reg]) begin
                    fault_next[ptr_reg]  = 1'b0;
                    active_next[ptr_reg] = 1'b1;
                    count_next           = count_next + 1'b1;
                    on_next[ptr_reg]     = 1'b1;
                end
                ptr_next = ptr_inc;
                if (ptr_reg == LAST_SLOT) begin
                    stat.scan_done = 1'b1;
                end
            end
        end
    end

    always_comb begin
        volt_low_next  = volt_low_reg;
        volt_high_next = volt_high_reg;
        temp_crit_next = temp_crit_reg;
        temp_warn_next = temp_warn_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                REG_VOLT_LOW:  volt_low_next  = cfg_wdata;
                REG_VOLT_HIGH: volt_high_next = cfg_wdata;
                REG_TEMP_CRIT: temp_crit_next = cfg_wdata[TEMP_W-1:0];
                REG_TEMP_WARN: temp_warn_next = cfg_wdata[TEMP_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            volt_low_reg  <= VOLT_LOW_RST;
            volt_high_reg <= VOLT_HIGH_RST;
            temp_crit_reg <= TEMP_CRIT_RST;
            temp_warn_reg <= TEMP_WARN_RST;
            active_reg    <= '0;
            fault_reg     <= '0;
            count_reg     <= '0;
            health_reg    <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            volt_low_reg  <= volt_low_next;
            volt_high_reg <= volt_high_next;
            temp_crit_reg <= temp_crit_next;
            temp_warn_reg <= temp_warn_next;
            active_reg    <= active_next;
            fault_reg     <= fault_next;
            count_reg     <= count_next;
            health_reg    <= health_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg      <= s_op;
            id_reg      <= s_servo_id;
            resp_reg    <= s_responded;
            mv_reg      <= s_voltage_mv;
            mv_ok_reg   <= s_voltage_valid;
            temp_reg    <= s_temp_c;
            temp_ok_reg <= s_temp_valid;
        end
        ptr_reg   <= ptr_next;
        tries_reg <= tries_next;
        found_reg <= found_next;
        event_reg <= event_next;
        evid_reg  <= evid_next;
        code_reg  <= code_next;
        val_reg   <= val_next;
        off_reg   <= off_next;
        on_reg    <= on_next;
        if (cmd.emit) begin
            m_slot_index      <= SLOT_W'(health_reg);
            m_slot_found      <= found_reg;
            m_fault_event     <= event_reg;
            m_fault_servo_id  <= evid_reg;
            m_fault_kind      <= code_reg;
            m_fault_reading   <= val_reg;
            m_torque_off_mask <= MASK_W'(off_reg);
            m_torque_on_mask  <= MASK_W'(on_reg);
            m_active_mask     <= MASK_W'(active_reg);
            m_active_count    <= SLOT_W'(count_reg);
        end
    end

    assign m_valid = m_valid_reg;

    a_state_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        (active_reg & fault_reg) == '0)
        else $error("slot both active and faulted");

    a_health_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        health_reg <= LAST_SLOT)
        else $error("health slot out of range");

    a_emit_needs_room: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> (!m_valid_reg || m_ready))
        else $error("result overwrites an untaken result");

    a_emit_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |=> m_valid_reg)
        else $error("emitted result not presented");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(MOTORS))
        else $error("active count exceeds slot count");

endmodule

// ----- rtl/core/servo_health_fault_supervisor.sv -----
// Servo health and fault supervisor: per-slot absent/active/fault tracking.
// Flow: an accepted item is applied, then its result moves to the output register;
// advance and fault-clear-all walk up to MOTORS slots in between (fault-clear-all
// always walks all MOTORS slots); a new item is accepted once that result has moved.
// Reset: synchronous, active low; all slots absent, count and health slot zero,
// thresholds to defaults. No clearing pass; an item can be taken right after reset.
module servo_health_fault_supervisor
    import shfs_pkg::*;
#(
    parameter int MOTORS = MOTORS_DEFAULT
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // Configuration write port
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    // Event items
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [OP_W-1:0]       s_op,
    input  logic [ID_W-1:0]       s_servo_id,
    input  logic                  s_responded,
    input  logic [MV_W-1:0]       s_voltage_mv,
    input  logic                  s_voltage_valid,
    input  logic [TEMP_W-1:0]     s_temp_c,
    input  logic                  s_temp_valid,
    // Result items
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [SLOT_W-1:0]     m_slot_index,
    output logic                  m_slot_found,
    output logic                  m_fault_event,
    output logic [SLOT_W-1:0]     m_fault_servo_id,
    output logic [CODE_W-1:0]     m_fault_kind,
    output logic [MV_W-1:0]       m_fault_reading,
    output logic [MASK_W-1:0]     m_torque_off_mask,
    output logic [MASK_W-1:0]     m_torque_on_mask,
    output logic [MASK_W-1:0]     m_active_mask,
    output logic [SLOT_W-1:0]     m_active_count
);

    // The sequencer walks idle -> apply -> optional slot walk -> deliver.
    // Input is taken only in idle; the output register holds a finished
    // result, so the next item is accepted while the sink stalls.
    shfs_cmd_t  cmd;
    shfs_stat_t stat;

    shfs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // Slot state lives as two bit vectors (active, fault); the active count
    // is kept incrementally so no population count over slots is needed.
    shfs_datapath #(
        .MOTORS (MOTORS)
    ) u_datapath (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .stat              (stat),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_index         (cfg_index),
        .cfg_wdata         (cfg_wdata),
        .s_op              (s_op),
        .s_servo_id        (s_servo_id),
        .s_responded       (s_responded),
        .s_voltage_mv      (s_voltage_mv),
        .s_voltage_valid   (s_voltage_valid),
        .s_temp_c          (s_temp_c),
        .s_temp_valid      (s_temp_valid),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_slot_index      (m_slot_index),
        .m_slot_found      (m_slot_found),
        .m_fault_event     (m_fault_event),
        .m_fault_servo_id  (m_fault_servo_id),
        .m_fault_kind      (m_fault_kind),
        .m_fault_reading   (m_fault_reading),
        .m_torque_off_mask (m_torque_off_mask),
        .m_torque_on_mask  (m_torque_on_mask),
        .m_active_mask     (m_active_mask),
        .m_active_count    (m_active_count)
    );

endmodule
